// ===== rtl/core/tcg_pkg.sv =====
// Shared types, constants and the glyph table of the teletext cell generator.
`timescale 1ns / 1ps

package tcg_pkg;

  // Cell geometry.
  localparam int CELL_LINES = 20;
  localparam logic [4:0] LAST_LINE = 5'(CELL_LINES - 1);
  localparam logic [4:0] TEXT_FIRST_LINE = 5'd3;
  localparam logic [4:0] TEXT_LAST_LINE = 5'd16;
  localparam logic [4:0] MOSAIC_FIRST_LINE = 5'd1;
  localparam logic [4:0] MOSAIC_LAST_LINE = 5'd18;
  localparam logic [4:0] MOSAIC_BLOCK_LINES = 5'd6;

  // Row length register.
  localparam logic [6:0] MAX_COLUMNS = 7'd80;
  localparam logic [6:0] COLUMNS_RESET = 7'd40;

  // Character codes.
  localparam logic [6:0] CODE_CTRL_LIMIT = 7'h20;
  localparam logic [6:0] CODE_FG_FIRST = 7'h01;
  localparam logic [6:0] CODE_FG_LAST = 7'h07;
  localparam logic [6:0] CODE_FLASH_ON = 7'h08;
  localparam logic [6:0] CODE_FLASH_OFF = 7'h09;
  localparam logic [6:0] CODE_GFX_FIRST = 7'h11;
  localparam logic [6:0] CODE_GFX_LAST = 7'h17;
  localparam logic [6:0] CODE_CONTIGUOUS = 7'h19;
  localparam logic [6:0] CODE_SEPARATED = 7'h1A;
  localparam logic [6:0] CODE_BLACK_BACK = 7'h1C;
  localparam logic [6:0] CODE_NEW_BACK = 7'h1D;
  localparam logic [6:0] CODE_LOWER_A = 7'h61;
  localparam logic [6:0] CODE_LOWER_Z = 7'h7A;
  localparam logic [6:0] CODE_CASE_FOLD = 7'h20;

  // Flash phase: frame_number / 25, reduced through residues modulo 25.
  localparam int FLASH_PERIOD = 25;
  localparam int FOLD_BITS = 20;
  localparam int RECIP_SHIFT = 20;
  localparam int FLASH_RECIP = (1 << RECIP_SHIFT) / FLASH_PERIOD;

  // Colors.
  localparam logic [2:0] COLOUR_WHITE = 3'd7;
  localparam logic [2:0] COLOUR_BLACK = 3'd0;

  // Depth of the attribute memory: one running attribute set.
  localparam int STATE_DEPTH = 1;
  localparam int STATE_AW = 1;

  // Running attribute set held in the attribute memory.
  typedef struct packed {
    logic [6:0] column_count;
    logic [2:0] fore_attr;
    logic [2:0] back_attr;
    logic       graphics_mode;
    logic       separated_mode;
    logic       flash_mode;
  } attr_state_t;

  localparam attr_state_t ATTR_RESET = '{
    column_count:   7'd0,
    fore_attr:      COLOUR_WHITE,
    back_attr:      COLOUR_BLACK,
    graphics_mode:  1'b0,
    separated_mode: 1'b0,
    flash_mode:     1'b0
  };

  // Everything the line sequencer needs to draw one cell.
  typedef struct packed {
    logic [6:0] code;
    logic       drawn;
    logic       graphics;
    logic       separated;
    logic [2:0] fore;
    logic [2:0] back;
  } cell_desc_t;

  // One 5-pixel row of the 5x7 font; bit 4 is the leftmost pixel.
  function automatic logic [4:0] glyph_row(input logic [6:0] idx, input logic [2:0] row);
    logic [34:0] rows;
    logic [4:0]  bits;
    case (idx)
      7'd1:  rows = {5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd4};
      7'd2:  rows = {5'd10, 5'd10, 5'd20, 5'd0, 5'd0, 5'd0, 5'd0};
      7'd3:  rows = {5'd10, 5'd10, 5'd31, 5'd10, 5'd31, 5'd10, 5'd10};
      7'd4:  rows = {5'd4, 5'd15, 5'd20, 5'd14, 5'd5, 5'd30, 5'd4};
      7'd5:  rows = {5'd17, 5'd2, 5'd4, 5'd8, 5'd16, 5'd17, 5'd0};
      7'd6:  rows = {5'd12, 5'd18, 5'd20, 5'd8, 5'd21, 5'd18, 5'd13};
      7'd7:  rows = {5'd4, 5'd4, 5'd8, 5'd0, 5'd0, 5'd0, 5'd0};
      7'd8:  rows = {5'd2, 5'd4, 5'd8, 5'd8, 5'd8, 5'd4, 5'd2};
      7'd9:  rows = {5'd8, 5'd4, 5'd2, 5'd2, 5'd2, 5'd4, 5'd8};
      7'd10: rows = {5'd0, 5'd17, 5'd10, 5'd31, 5'd10, 5'd17, 5'd0};
      7'd11: rows = {5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0};
      7'd12: rows = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd8};
      7'd13: rows = {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      7'd14: rows = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12};
      7'd15: rows = {5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16};
      7'd16: rows = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      7'd17: rows = {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      7'd18: rows = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      7'd19: rows = {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      7'd20: rows = {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      7'd21: rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      7'd22: rows = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      7'd23: rows = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      7'd24: rows = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      7'd25: rows = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
      7'd26: rows = {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0};
      7'd27: rows = {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd8, 5'd0};
      7'd28: rows = {5'd2, 5'd4, 5'd8, 5'd16, 5'd8, 5'd4, 5'd2};
      7'd29: rows = {5'd0, 5'd0, 5'd31, 5'd0, 5'd31, 5'd0, 5'd0};
      7'd30: rows = {5'd8, 5'd4, 5'd2, 5'd1, 5'd2, 5'd4, 5'd8};
      7'd31: rows = {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
      7'd32: rows = {5'd14, 5'd17, 5'd23, 5'd21, 5'd23, 5'd16, 5'd14};
      7'd33: rows = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      7'd34: rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      7'd35: rows = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      7'd36: rows = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      7'd37: rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      7'd38: rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      7'd39: rows = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
      7'd40: rows = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      7'd41: rows = {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      7'd42: rows = {5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd18, 5'd12};
      7'd43: rows = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      7'd44: rows = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      7'd45: rows = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      7'd46: rows = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      7'd47: rows = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      7'd48: rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      7'd49: rows = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      7'd50: rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      7'd51: rows = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      7'd52: rows = {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      7'd53: rows = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      7'd54: rows = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      7'd55: rows = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      7'd56: rows = {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      7'd57: rows = {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      7'd58: rows = {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      7'd59: rows = {5'd14, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd14};
      7'd60: rows = {5'd16, 5'd8, 5'd8, 5'd4, 5'd2, 5'd2, 5'd1};
      7'd61: rows = {5'd14, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd14};
      7'd62: rows = {5'd4, 5'd10, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0};
      7'd63: rows = {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31};
      7'd64: rows = {5'd8, 5'd4, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0};
      7'd92: rows = {5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      7'd94: rows = {5'd0, 5'd0, 5'd9, 5'd22, 5'd0, 5'd0, 5'd0};
      default: rows = '0;
    endcase
    case (row)
      3'd0:    bits = rows[34:30];
      3'd1:    bits = rows[29:25];
      3'd2:    bits = rows[24:20];
      3'd3:    bits = rows[19:15];
      3'd4:    bits = rows[14:10];
      3'd5:    bits = rows[9:5];
      3'd6:    bits = rows[4:0];
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

// ===== rtl/core/tcg_if.sv =====
// Valid/ready channel interfaces for the character input and the cell line output.
`timescale 1ns / 1ps

interface tcg_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  character_byte;
  logic [63:0] frame_number;

  modport source(output valid, output character_byte, output frame_number, input ready);
  modport sink(input valid, input character_byte, input frame_number, output ready);
endinterface

interface tcg_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  line_in_cell;
  logic [11:0] pixel_mask;
  logic [2:0]  fore_colour;
  logic [2:0]  back_colour;
  logic        last_line;

  modport source(output valid, output line_in_cell, output pixel_mask, output fore_colour,
                 output back_colour, output last_line, input ready);
  modport sink(input valid, input line_in_cell, input pixel_mask, input fore_colour,
               input back_colour, input last_line, output ready);
endinterface

// ===== rtl/core/tcg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module tcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tcg_line_gen.sv =====
// Cell line sequencer: draws the 20 pixel lines of one cell, one line per output item.
`timescale 1ns / 1ps

module tcg_line_gen import tcg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_desc_t        desc,
  input  logic              desc_valid,
  output logic              desc_take,
  tcg_out_if.source         out_item
);

  cell_desc_t  cur_r;
  logic        cur_valid_r;
  logic [4:0]  line_r;
  logic        out_fire;
  logic        at_last;

  logic [6:0]  folded_code;
  logic [6:0]  glyph_idx;
  logic [4:0]  text_off;
  logic [4:0]  glyph_bits;
  logic [11:0] text_mask;
  logic [4:0]  mos_y;
  logic [4:0]  mos_ry;
  logic [1:0]  block_pair;
  logic        mos_gap;
  logic [11:0] left_block;
  logic [11:0] right_block;
  logic [11:0] mosaic_mask;
  logic [11:0] mask;

  assign at_last   = (line_r == LAST_LINE);
  assign out_fire  = cur_valid_r && out_item.ready;
  assign desc_take = !cur_valid_r || (out_fire && at_last);

  // Cell register and line counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      line_r      <= '0;
    end else if (desc_take) begin
      cur_valid_r <= desc_valid;
      line_r      <= '0;
    end else if (out_fire) begin
      line_r <= line_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_take) begin
      cur_r <= desc;
    end
  end

  // Text glyph: lower case folds to upper case, each font pixel doubled.
  always_comb begin
    folded_code = cur_r.code;
    if (cur_r.code >= CODE_LOWER_A && cur_r.code <= CODE_LOWER_Z) begin
      folded_code = cur_r.code - CODE_CASE_FOLD;
    end
    glyph_idx  = folded_code - CODE_CTRL_LIMIT;
    text_off   = line_r - TEXT_FIRST_LINE;
    glyph_bits = glyph_row(glyph_idx, text_off[3:1]);
    text_mask  = '0;
    if (line_r >= TEXT_FIRST_LINE && line_r <= TEXT_LAST_LINE) begin
      text_mask = {1'b0, {2{glyph_bits[4]}}, {2{glyph_bits[3]}}, {2{glyph_bits[2]}},
                   {2{glyph_bits[1]}}, {2{glyph_bits[0]}}, 1'b0};
    end
  end

  // Mosaic: three rows of two 6x6 blocks starting on line 1.
  always_comb begin
    mos_y = line_r - MOSAIC_FIRST_LINE;
    if (mos_y < MOSAIC_BLOCK_LINES) begin
      block_pair = cur_r.code[1:0];
      mos_ry     = mos_y;
    end else if (mos_y < 5'(2 * MOSAIC_BLOCK_LINES)) begin
      block_pair = cur_r.code[3:2];
      mos_ry     = mos_y - MOSAIC_BLOCK_LINES;
    end else begin
      block_pair = cur_r.code[5:4];
      mos_ry     = mos_y - 5'(2 * MOSAIC_BLOCK_LINES);
    end
    mos_gap     = cur_r.separated &&
                  (mos_ry == 5'd0 || mos_ry == MOSAIC_BLOCK_LINES - 5'd1);
    left_block  = cur_r.separated ? 12'b0111_1000_0000 : 12'b1111_1100_0000;
    right_block = cur_r.separated ? 12'b0000_0001_1110 : 12'b0000_0011_1111;
    mosaic_mask = '0;
    if (line_r >= MOSAIC_FIRST_LINE && line_r <= MOSAIC_LAST_LINE && !mos_gap) begin
      mosaic_mask = (block_pair[0] ? left_block : 12'b0) |
                    (block_pair[1] ? right_block : 12'b0);
    end
  end

  // Blank for control cells and for flashing cells in their hidden phase.
  always_comb begin
    mask = '0;
    if (cur_r.drawn) begin
      mask = cur_r.graphics ? mosaic_mask : text_mask;
    end
  end

  assign out_item.valid        = cur_valid_r;
  assign out_item.line_in_cell = line_r;
  assign out_item.pixel_mask   = mask;
  assign out_item.fore_colour  = cur_r.fore;
  assign out_item.back_colour  = cur_r.back;
  assign out_item.last_line    = at_last;

endmodule

// ===== rtl/core/teletext_cell_generator.sv =====
// Top level of the teletext cell generator: attribute update, flash phase and line output.
//
//   channel   direction  handshake       payload
//   in_item   input      valid / ready   character_byte[7:0], frame_number[63:0]
//   out_item  output     valid / ready   line_in_cell, pixel_mask, fore_colour,
//                                        back_colour, last_line
//   cfg       input      cfg_we          cfg_wdata[6:0] = columns_per_row
//
// Each character gives 20 output items, one per cycle while the output is ready, and
// the sequencer takes the next character as the last line of a cell leaves. Each character
// passes stages A, B and C and the cell register before its first line. The running
// attributes sit in a one-entry memory, read at accept and written back as stage A moves
// on, with forwarding between neighbors. Up to three characters wait in the pipeline while
// a cell is drawn, and a stalled output holds its line. Reset is synchronous; no clearing pass is needed.
`timescale 1ns / 1ps

module teletext_cell_generator import tcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tcg_in_if.sink      in_item,
  tcg_out_if.source   out_item,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  logic [6:0]  cols_r;
  logic        state_valid_r;
  logic        rd_valid_r;
  logic        fwd_valid_r;
  attr_state_t fwd_data_r;

  logic        in_accept;
  logic        ready_a;
  logic        ready_b;
  logic        ready_c;
  logic        desc_take;

  // Stage A: attribute read-modify-write.
  logic        a_valid_r;
  logic [6:0]  a_code_r;
  logic [21:0] a_sum_r;
  logic        a_f0_r;

  // Stage B: residue multiply.
  logic        b_valid_r;
  cell_desc_t  b_cell_r;
  logic        b_flash_r;
  logic [20:0] b_t_r;
  logic        b_f0_r;

  // Stage C: residue correction, waiting for the line sequencer.
  logic        c_valid_r;
  cell_desc_t  c_cell_r;
  logic        c_flash_r;
  logic [20:0] c_t_r;
  logic [16:0] c_q_r;
  logic        c_f0_r;

  attr_state_t ram_rdata;
  attr_state_t state_cur;
  attr_state_t state_mod;
  attr_state_t state_wdata;
  logic        state_we;
  logic        a_control;
  logic [6:0]  cols_used;
  logic [6:0]  col_next;
  logic        row_end;
  logic [20:0] a_t;
  cell_desc_t  a_cell;
  logic [36:0] b_prod;
  logic [21:0] c_q25;
  logic [21:0] c_rem_wide;
  logic [5:0]  c_rem;
  logic [5:0]  c_rem_fix;
  logic        c_hidden;
  cell_desc_t  c_desc;
  logic [21:0] in_sum;

  // Pipeline flow: a stage takes a new item when empty or when it moves on.
  assign ready_c       = !c_valid_r || desc_take;
  assign ready_b       = !b_valid_r || ready_c;
  assign ready_a       = !a_valid_r || ready_b;
  assign in_item.ready = ready_a;
  assign in_accept     = in_item.valid && ready_a;
  assign state_we      = a_valid_r && ready_b;

  // Residue of frame_number modulo 25: 2^20 is 1 modulo 25, so 20-bit chunks add up.
  assign in_sum = 22'(in_item.frame_number[FOLD_BITS-1:0]) +
                  22'(in_item.frame_number[2*FOLD_BITS-1:FOLD_BITS]) +
                  22'(in_item.frame_number[3*FOLD_BITS-1:2*FOLD_BITS]) +
                  22'(in_item.frame_number[63:3*FOLD_BITS]);

  tcg_ram #(
    .WIDTH ($bits(attr_state_t)),
    .DEPTH (STATE_DEPTH)
  ) u_attr_ram (
    .clk   (clk),
    .we    (state_we),
    .waddr (STATE_AW'(0)),
    .wdata (state_wdata),
    .re    (in_accept),
    .raddr (STATE_AW'(0)),
    .rdata (ram_rdata)
  );

  // Current attributes: forwarded write, memory, or reset value before the first write.
  always_comb begin
    if (fwd_valid_r) begin
      state_cur = fwd_data_r;
    end else if (rd_valid_r) begin
      state_cur = ram_rdata;
    end else begin
      state_cur = ATTR_RESET;
    end
  end

  // Control code decode.
  assign a_control = (a_code_r < CODE_CTRL_LIMIT);

  always_comb begin
    state_mod = state_cur;
    if (a_control) begin
      case (a_code_r) inside
        [CODE_FG_FIRST:CODE_FG_LAST]: begin
          state_mod.fore_attr     = a_code_r[2:0];
          state_mod.graphics_mode = 1'b0;
        end
        [CODE_GFX_FIRST:CODE_GFX_LAST]: begin
          state_mod.fore_attr     = a_code_r[2:0];
          state_mod.graphics_mode = 1'b1;
        end
        CODE_FLASH_ON:   state_mod.flash_mode     = 1'b1;
        CODE_FLASH_OFF:  state_mod.flash_mode     = 1'b0;
        CODE_CONTIGUOUS: state_mod.separated_mode = 1'b0;
        CODE_SEPARATED:  state_mod.separated_mode = 1'b1;
        CODE_BLACK_BACK: state_mod.back_attr      = COLOUR_BLACK;
        CODE_NEW_BACK:   state_mod.back_attr      = state_cur.fore_attr;
        default: ;
      endcase
    end
  end

  // Column count and row end, against the clamped row length.
  always_comb begin
    if (cols_r == 7'd0) begin
      cols_used = 7'd1;
    end else if (cols_r > MAX_COLUMNS) begin
      cols_used = MAX_COLUMNS;
    end else begin
      cols_used = cols_r;
    end
    col_next = state_cur.column_count + 7'd1;
    row_end  = (col_next >= cols_used) || (col_next == 7'd0);
    if (row_end) begin
      state_wdata = ATTR_RESET;
    end else begin
      state_wdata              = state_mod;
      state_wdata.column_count = col_next;
    end
  end

  // Cell fields as drawn, taken after the control code and before the row reset.
  always_comb begin
    a_cell.code      = a_code_r;
    a_cell.drawn     = !a_control;
    a_cell.graphics  = state_mod.graphics_mode;
    a_cell.separated = state_mod.separated_mode;
    a_cell.fore      = a_control ? COLOUR_BLACK : state_mod.fore_attr;
    a_cell.back      = a_control ? COLOUR_BLACK : state_mod.back_attr;
  end

  assign a_t = 21'(a_sum_r[FOLD_BITS-1:0]) + 21'(a_sum_r[21:FOLD_BITS]);

  // Quotient estimate of t / 25, low by at most one.
  assign b_prod = 37'(b_t_r) * 37'(FLASH_RECIP);

  // Remainder with one correction; frame / 25 is odd when its parity differs from bit 0.
  always_comb begin
    c_q25      = 22'(c_q_r) * 22'(FLASH_PERIOD);
    c_rem_wide = 22'(c_t_r) - c_q25;
    c_rem      = c_rem_wide[5:0];
    c_rem_fix  = (c_rem >= 6'(FLASH_PERIOD)) ? c_rem - 6'(FLASH_PERIOD) : c_rem;
    c_hidden   = c_flash_r && (c_rem_fix[0] ^ c_f0_r);
    c_desc       = c_cell_r;
    c_desc.drawn = c_cell_r.drawn && !c_hidden;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r        <= COLUMNS_RESET;
      state_valid_r <= 1'b0;
      rd_valid_r    <= 1'b0;
      fwd_valid_r   <= 1'b0;
      a_valid_r     <= 1'b0;
      b_valid_r     <= 1'b0;
      c_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        cols_r <= cfg_wdata;
      end
      if (state_we) begin
        state_valid_r <= 1'b1;
      end
      if (in_accept) begin
        rd_valid_r  <= state_valid_r;
        fwd_valid_r <= state_we;
      end
      if (ready_a) begin
        a_valid_r <= in_item.valid;
      end
      if (ready_b) begin
        b_valid_r <= a_valid_r;
      end
      if (ready_c) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_code_r   <= in_item.character_byte[6:0];
      a_sum_r    <= in_sum;
      a_f0_r     <= in_item.frame_number[0];
      fwd_data_r <= state_wdata;
    end
    if (ready_b) begin
      b_cell_r  <= a_cell;
      b_flash_r <= state_mod.flash_mode;
      b_t_r     <= a_t;
      b_f0_r    <= a_f0_r;
    end
    if (ready_c) begin
      c_cell_r  <= b_cell_r;
      c_flash_r <= b_flash_r;
      c_t_r     <= b_t_r;
      c_q_r     <= b_prod[36:RECIP_SHIFT];
      c_f0_r    <= b_f0_r;
    end
  end

  tcg_line_gen u_line_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (c_desc),
    .desc_valid (c_valid_r),
    .desc_take  (desc_take),
    .out_item   (out_item)
  );

endmodule

// ===== rtl/core/tcg_checker.sv =====
// Port-level assertions for the teletext cell generator, bound to the top level.
`timescale 1ns / 1ps

module tcg_checker import tcg_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_line_in_cell,
  input logic [11:0] out_pixel_mask,
  input logic        out_last_line
);

  // A stalled output item holds its line and pixels.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_in_cell) &&
    $stable(out_pixel_mask))
    else $error("output item changed while stalled");

  // last_line marks exactly the final line of a cell.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_line == (out_line_in_cell == LAST_LINE)))
    else $error("last_line does not match line_in_cell");

  // Within a cell, lines follow one another without gaps.
  a_line_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_line |=>
    out_valid && (out_line_in_cell == $past(out_line_in_cell) + 5'd1))
    else $error("cell lines out of sequence");

  // A new cell starts on its top line.
  a_cell_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_line |=> !out_valid || (out_line_in_cell == 5'd0))
    else $error("cell does not start on line zero");

endmodule

bind teletext_cell_generator tcg_checker u_tcg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_item.valid),
  .out_ready        (out_item.ready),
  .out_line_in_cell (out_item.line_in_cell),
  .out_pixel_mask   (out_item.pixel_mask),
  .out_last_line    (out_item.last_line)
);

// ===== test/tb.sv =====
// Self-checking testbench for the teletext cell generator: random and directed characters.
`timescale 1ns / 1ps

module tb import tcg_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [6:0] CODE_NULL = 7'h00;

  // One cell line as seen on the output channel.
  typedef struct packed {
    logic [4:0]  line_in_cell;
    logic [11:0] pixel_mask;
    logic [2:0]  fore_colour;
    logic [2:0]  back_colour;
    logic        last_line;
  } cell_line_t;

  // Running attribute model and the queue of cell lines still to come.
  class cell_scoreboard;
    cell_line_t  expected_lines[$];
    int          errors;
    logic [4:0]  font[96][7];
    logic [6:0]  columns;
    logic [6:0]  column_count;
    logic [2:0]  fore_attr;
    logic [2:0]  back_attr;
    logic        graphics_mode;
    logic        separated_mode;
    logic        flash_mode;

    function new();
      errors = 0;
      columns = COLUMNS_RESET;
      column_count = '0;
      reset_attributes();
      foreach (font[i, j]) font[i][j] = '0;
      font[1]  = '{4, 4, 4, 4, 4, 0, 4};        font[2]  = '{10, 10, 20, 0, 0, 0, 0};
      font[3]  = '{10, 10, 31, 10, 31, 10, 10}; font[4]  = '{4, 15, 20, 14, 5, 30, 4};
      font[5]  = '{17, 2, 4, 8, 16, 17, 0};     font[6]  = '{12, 18, 20, 8, 21, 18, 13};
      font[7]  = '{4, 4, 8, 0, 0, 0, 0};        font[8]  = '{2, 4, 8, 8, 8, 4, 2};
      font[9]  = '{8, 4, 2, 2, 2, 4, 8};        font[10] = '{0, 17, 10, 31, 10, 17, 0};
      font[11] = '{0, 4, 4, 31, 4, 4, 0};       font[12] = '{0, 0, 0, 0, 0, 12, 8};
      font[13] = '{0, 0, 0, 31, 0, 0, 0};       font[14] = '{0, 0, 0, 0, 0, 12, 12};
      font[15] = '{1, 2, 2, 4, 8, 8, 16};       font[16] = '{14, 17, 19, 21, 25, 17, 14};
      font[17] = '{4, 12, 4, 4, 4, 4, 14};      font[18] = '{14, 17, 1, 2, 4, 8, 31};
      font[19] = '{30, 1, 1, 14, 1, 1, 30};     font[20] = '{2, 6, 10, 18, 31, 2, 2};
      font[21] = '{31, 16, 16, 30, 1, 1, 30};   font[22] = '{14, 16, 16, 30, 17, 17, 14};
      font[23] = '{31, 1, 2, 4, 8, 8, 8};       font[24] = '{14, 17, 17, 14, 17, 17, 14};
      font[25] = '{14, 17, 17, 15, 1, 1, 14};   font[26] = '{0, 12, 12, 0, 12, 12, 0};
      font[27] = '{0, 12, 12, 0, 12, 8, 0};     font[28] = '{2, 4, 8, 16, 8, 4, 2};
      font[29] = '{0, 0, 31, 0, 31, 0, 0};      font[30] = '{8, 4, 2, 1, 2, 4, 8};
      font[31] = '{14, 17, 1, 2, 4, 0, 4};      font[32] = '{14, 17, 23, 21, 23, 16, 14};
      font[33] = '{14, 17, 17, 31, 17, 17, 17}; font[34] = '{30, 17, 17, 30, 17, 17, 30};
      font[35] = '{14, 17, 16, 16, 16, 17, 14}; font[36] = '{30, 17, 17, 17, 17, 17, 30};
      font[37] = '{31, 16, 16, 30, 16, 16, 31}; font[38] = '{31, 16, 16, 30, 16, 16, 16};
      font[39] = '{14, 17, 16, 23, 17, 17, 15}; font[40] = '{17, 17, 17, 31, 17, 17, 17};
      font[41] = '{14, 4, 4, 4, 4, 4, 14};      font[42] = '{7, 2, 2, 2, 2, 18, 12};
      font[43] = '{17, 18, 20, 24, 20, 18, 17}; font[44] = '{16, 16, 16, 16, 16, 16, 31};
      font[45] = '{17, 27, 21, 21, 17, 17, 17}; font[46] = '{17, 25, 21, 19, 17, 17, 17};
      font[47] = '{14, 17, 17, 17, 17, 17, 14}; font[48] = '{30, 17, 17, 30, 16, 16, 16};
      font[49] = '{14, 17, 17, 17, 21, 18, 13}; font[50] = '{30, 17, 17, 30, 20, 18, 17};
      font[51] = '{15, 16, 16, 14, 1, 1, 30};   font[52] = '{31, 4, 4, 4, 4, 4, 4};
      font[53] = '{17, 17, 17, 17, 17, 17, 14}; font[54] = '{17, 17, 17, 17, 17, 10, 4};
      font[55] = '{17, 17, 17, 21, 21, 21, 10}; font[56] = '{17, 17, 10, 4, 10, 17, 17};
      font[57] = '{17, 17, 10, 4, 4, 4, 4};     font[58] = '{31, 1, 2, 4, 8, 16, 31};
      font[59] = '{14, 8, 8, 8, 8, 8, 14};      font[60] = '{16, 8, 8, 4, 2, 2, 1};
      font[61] = '{14, 2, 2, 2, 2, 2, 14};      font[62] = '{4, 10, 17, 0, 0, 0, 0};
      font[63] = '{0, 0, 0, 0, 0, 0, 31};       font[64] = '{8, 4, 2, 0, 0, 0, 0};
      font[92] = '{4, 4, 4, 4, 4, 4, 4};        font[94] = '{0, 0, 9, 22, 0, 0, 0};
    endfunction

    function void reset_attributes();
      fore_attr = COLOUR_WHITE;
      back_attr = COLOUR_BLACK;
      graphics_mode = 1'b0;
      separated_mode = 1'b0;
      flash_mode = 1'b0;
    endfunction

    function void write_columns(logic [6:0] value);
      columns = value;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    // Control codes only change the running attributes.
    function void apply_control(logic [6:0] code);
      if (code >= CODE_FG_FIRST && code <= CODE_FG_LAST) begin
        fore_attr = code[2:0];
        graphics_mode = 1'b0;
      end else if (code == CODE_FLASH_ON) begin
        flash_mode = 1'b1;
      end else if (code == CODE_FLASH_OFF) begin
        flash_mode = 1'b0;
      end else if (code >= CODE_GFX_FIRST && code <= CODE_GFX_LAST) begin
        fore_attr = code[2:0];
        graphics_mode = 1'b1;
      end else if (code == CODE_CONTIGUOUS) begin
        separated_mode = 1'b0;
      end else if (code == CODE_SEPARATED) begin
        separated_mode = 1'b1;
      end else if (code == CODE_BLACK_BACK) begin
        back_attr = COLOUR_BLACK;
      end else if (code == CODE_NEW_BACK) begin
        back_attr = fore_attr;
      end
    endfunction

    // Doubled 5x7 glyph, placed three lines down and one pixel in.
    function logic [11:0] text_row(logic [6:0] code, logic [4:0] line);
      logic [6:0]  idx;
      logic [4:0]  bits;
      logic [11:0] mask;
      mask = '0;
      if (line < TEXT_FIRST_LINE || line > TEXT_LAST_LINE) return mask;
      if (code >= CODE_LOWER_A && code <= CODE_LOWER_Z) code = code - CODE_CASE_FOLD;
      idx = code - CODE_CTRL_LIMIT;
      bits = font[idx][(line - TEXT_FIRST_LINE) / 2];
      for (int gx = 0; gx < 5; gx++) begin
        if (bits[4 - gx]) mask = mask | (12'b11 << (9 - 2 * gx));
      end
      return mask;
    endfunction

    // 2x3 mosaic of 6x6 blocks starting on line 1; separated blocks lose their border.
    function logic [11:0] mosaic_row(logic [6:0] code, logic [4:0] line);
      logic [11:0] mask;
      int gap, y, by, ry;
      mask = '0;
      gap = separated_mode ? 1 : 0;
      if (line < MOSAIC_FIRST_LINE || line > MOSAIC_LAST_LINE) return mask;
      y = line - MOSAIC_FIRST_LINE;
      by = y / 6;
      ry = y % 6;
      if (ry < gap || ry >= 6 - gap) return mask;
      for (int bx = 0; bx < 2; bx++) begin
        if (code[by * 2 + bx]) begin
          for (int x = bx * 6 + gap; x < bx * 6 + 6 - gap; x++) mask[11 - x] = 1'b1;
        end
      end
      return mask;
    endfunction

    // Queue the 20 lines of one accepted character and advance the row position.
    function void note_character(logic [7:0] char_byte, logic [63:0] frame);
      logic [6:0] code;
      logic [6:0] row_len;
      logic       is_control;
      logic       shown;
      cell_line_t want;
      code = char_byte[6:0];
      is_control = code < CODE_CTRL_LIMIT;
      row_len = columns;
      if (row_len == 0) row_len = 7'd1;
      if (row_len > MAX_COLUMNS) row_len = MAX_COLUMNS;
      if (is_control) apply_control(code);
      shown = !flash_mode || ((frame / 64'd25) % 2 == 0);
      for (int line = 0; line < CELL_LINES; line++) begin
        want.line_in_cell = 5'(line);
        want.pixel_mask = '0;
        if (!is_control && shown) begin
          want.pixel_mask = graphics_mode ? mosaic_row(code, 5'(line)) : text_row(code, 5'(line));
        end
        want.fore_colour = is_control ? COLOUR_BLACK : fore_attr;
        want.back_colour = is_control ? COLOUR_BLACK : back_attr;
        want.last_line = (line == CELL_LINES - 1);
        expected_lines.push_back(want);
      end
      column_count = column_count + 7'd1;
      if (column_count >= row_len || column_count == 0) begin
        column_count = '0;
        reset_attributes();
      end
    endfunction

    // Compare one received cell line with the oldest expected one.
    function void check_line(cell_line_t got);
      cell_line_t want;
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t: unexpected cell line: line %0d mask %h fg %0d bg %0d last %0d",
                 $time, got.line_in_cell, got.pixel_mask, got.fore_colour,
                 got.back_colour, got.last_line);
        return;
      end
      want = expected_lines.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: cell line mismatch: expected line %0d mask %h fg %0d bg %0d last %0d",
                 $time, want.line_in_cell, want.pixel_mask, want.fore_colour,
                 want.back_colour, want.last_line);
        $display("%0t:                        got line %0d mask %h fg %0d bg %0d last %0d",
                 $time, got.line_in_cell, got.pixel_mask, got.fore_colour,
                 got.back_colour, got.last_line);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_wdata;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       long_hold_pending = 1'b0;
  int         stall_cycles = 0;
  cell_scoreboard sb;

  tcg_in_if  in_ch();
  tcg_out_if out_ch();

  teletext_cell_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one character, with random idle cycles before it, and note it once accepted.
  task automatic send_character(input logic [7:0] char_byte, input logic [63:0] frame);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.character_byte <= char_byte;
    in_ch.frame_number <= frame;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_character(char_byte, frame);
  endtask

  // Stop offering, wait for every expected line, then let the pipeline settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Row length is only changed while the block is idle.
  task automatic set_columns(input logic [6:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    sb.write_columns(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random characters: mostly printable cells, many control codes, some raw bytes.
  task automatic send_random(input int count);
    logic [7:0]  char_byte;
    logic [63:0] frame;
    int          pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 35) char_byte = 8'($urandom) & 8'h9F;
      else if (pick < 45) char_byte = 8'($urandom);
      else char_byte = {1'($urandom), 7'($urandom_range(127, 32))};
      if ($urandom_range(1) == 0) frame = 64'($urandom_range(99));
      else frame = {$urandom, $urandom};
      send_character(char_byte, frame);
    end
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_pending <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every accepted cell line.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_line('{out_ch.line_in_cell, out_ch.pixel_mask, out_ch.fore_colour,
                      out_ch.back_colour, out_ch.last_line});
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Main sequence: reset, directed characters, then random phases at several row lengths.
  initial begin
    sb = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.character_byte <= '0;
    in_ch.frame_number <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 23;
    recv_idle_pct = 48;
    set_columns(COLUMNS_RESET);

    // Text cells, case folding, bit 7 and glyph-less codes.
    send_character(8'h41, 64'd0);
    send_character(8'hE1, 64'd24);
    send_character({1'b1, CODE_FG_FIRST + 7'd2}, 64'd0);
    send_character({1'b0, CODE_NEW_BACK}, 64'd0);
    send_character(8'h7F, 64'd0);
    send_character(8'h7C, 64'd0);
    send_character(8'h7E, 64'd0);
    send_character(8'h20, 64'd0);
    send_character(8'h60, 64'd0);
    send_character(8'h7B, 64'd0);
    // Contiguous and separated mosaics.
    send_character({1'b0, CODE_GFX_FIRST + 7'd1}, 64'd0);
    send_character(8'h7F, 64'd0);
    send_character({1'b0, CODE_SEPARATED}, 64'd0);
    send_character(8'h7F, 64'd0);
    send_character(8'h35, 64'd0);
    send_character({1'b0, CODE_CONTIGUOUS}, 64'd0);
    send_character(8'h6A, 64'd0);
    // Flash: hidden on an odd phase, shown on the largest frame number.
    send_character({1'b0, CODE_FLASH_ON}, 64'd0);
    send_character(8'h7F, 64'd25);
    send_character(8'h7F, 64'hFFFF_FFFF_FFFF_FFFF);
    send_character({1'b0, CODE_FLASH_OFF}, 64'd25);
    send_character({1'b0, CODE_BLACK_BACK}, 64'd0);
    send_character({1'b0, CODE_NULL}, 64'd0);
    send_character({1'b0, CODE_FG_LAST}, 64'd0);
    send_character(8'h5A, 64'd25);

    // Row length above the maximum is clamped.
    set_columns(7'd127);
    send_random(25);

    // Row length zero acts as one.
    send_idle_pct = 48;
    recv_idle_pct = 23;
    set_columns(7'd0);
    send_random(15);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_columns(7'd3);
    send_random(25);

    // Long receiver hold-off so the block fills and stalls its input.
    set_columns(MAX_COLUMNS);
    long_hold_pending <= 1'b1;
    send_random(20);

    wait_drained();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tcg_pkg.sv
rtl/core/tcg_if.sv
rtl/core/tcg_ram.sv
rtl/core/tcg_line_gen.sv
rtl/core/teletext_cell_generator.sv
rtl/core/tcg_checker.sv
test/tb.sv
